>>> sv/mersenne_twister_generator_defines.svh
// Assertion macros shared by the generator's checker.
`ifndef MERSENNE_TWISTER_GENERATOR_DEFINES_SVH
`define MERSENNE_TWISTER_GENERATOR_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, idle while i_rst_n is low.
`define MTG_ASSERT_IMP(label, lhs, rhs) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (lhs) |-> (rhs)) \
        else $error("mtg check failed");

// Next-cycle implication, sampled on i_clk, idle while i_rst_n is low.
`define MTG_ASSERT_NXT(label, lhs, rhs) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (lhs) |=> (rhs)) \
        else $error("mtg check failed");

`endif

>>> sv/mtg_pkg.sv
// Types and constants of the MT19937 generator.
`timescale 1ns / 1ps
`default_nettype none

package mtg_pkg;

    localparam int STATE_WORDS   = 624;
    localparam int MIDDLE_OFFSET = 397;
    localparam int WORD_W        = 32;

    localparam logic [WORD_W-1:0] SEED_MULT  = 32'h6c078965;
    localparam logic [WORD_W-1:0] TWIST_XOR  = 32'h9908b0df;
    localparam logic [WORD_W-1:0] UPPER_BIT  = 32'h80000000;
    localparam logic [WORD_W-1:0] LOWER_BITS = 32'h7FFFFFFF;
    localparam logic [WORD_W-1:0] TEMPER_B   = 32'h9d2c5680;
    localparam logic [WORD_W-1:0] TEMPER_C   = 32'hefc60000;

    typedef enum logic {
        OP_DRAW = 1'b0,
        OP_SEED = 1'b1
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [WORD_W-1:0] seed_value;
    } t_in_item;

    typedef struct packed {
        logic [WORD_W-1:0] random_word;
    } t_out_item;

    // Words that feed the twist of one state entry.
    typedef struct packed {
        logic [WORD_W-1:0] w_pos;
        logic [WORD_W-1:0] w_next;
        logic [WORD_W-1:0] w_mid;
    } t_twist_in;

endpackage

`default_nettype wire

>>> sv/mtg_stream_if.sv
// Valid/ready stream channel with a typed payload.
`timescale 1ns / 1ps
`default_nettype none

interface mtg_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> sv/mtg_ram.sv
// Generic RAM: one write port, two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module mtg_ram #(
    parameter int WIDTH = mtg_pkg::WORD_W,
    parameter int DEPTH = mtg_pkg::STATE_WORDS,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr_a,
    input  wire logic [AW-1:0]    i_raddr_b,
    output logic      [WIDTH-1:0] o_rdata_a,
    output logic      [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

>>> sv/mtg_twist.sv
// Twist of one state word and tempering of the result.
`timescale 1ns / 1ps
`default_nettype none

module mtg_twist (
    input  wire mtg_pkg::t_twist_in             i_words,
    output logic [mtg_pkg::WORD_W-1:0]          o_new_word,
    output logic [mtg_pkg::WORD_W-1:0]          o_tempered
);

    logic [mtg_pkg::WORD_W-1:0] y;
    logic [mtg_pkg::WORD_W-1:0] t1;
    logic [mtg_pkg::WORD_W-1:0] t2;
    logic [mtg_pkg::WORD_W-1:0] t3;

    always_comb begin
        y = (i_words.w_pos & mtg_pkg::UPPER_BIT) | (i_words.w_next & mtg_pkg::LOWER_BITS);
        o_new_word = i_words.w_mid ^ (y >> 1);
        if (y[0]) begin
            o_new_word = o_new_word ^ mtg_pkg::TWIST_XOR;
        end
        t1 = o_new_word ^ (o_new_word >> 11);
        t2 = t1 ^ ((t1 << 7) & mtg_pkg::TEMPER_B);
        t3 = t2 ^ ((t2 << 15) & mtg_pkg::TEMPER_C);
        o_tempered = t3 ^ (t3 >> 18);
    end

endmodule

`default_nettype wire

>>> sv/mersenne_twister_generator.sv
// MT19937 generator: state RAM, seed sequencer and lazy per-word twist.
//
//  channel  dir  payload                    transaction
//  i_in     in   op, seed_value             i_in.valid & i_in.ready
//  o_out    out  random_word                o_out.valid & o_out.ready
//
// A draw runs through address issue, a read of the middle word over the
// same RAM port, then twist, temper and write-back; the middle word shares
// port A with the current word. A seed writes word 0 on acceptance, then
// one multiply and one add per further word. No result leaves for a seed.
// Reset needs no clearing pass: a seeded flag makes draws return zero until
// the first seed. A full output register stalls the write-back of a draw.
`timescale 1ns / 1ps
`default_nettype none

module mersenne_twister_generator #(
    parameter int STATE_WORDS   = mtg_pkg::STATE_WORDS,
    parameter int MIDDLE_OFFSET = mtg_pkg::MIDDLE_OFFSET
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    mtg_stream_if.sink   i_in,
    mtg_stream_if.source o_out
);

    localparam int AW = $clog2(STATE_WORDS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(STATE_WORDS - 1);
    localparam logic [AW-1:0] MID_OFF   = AW'(MIDDLE_OFFSET);
    localparam logic [AW-1:0] MID_SPLIT = AW'(STATE_WORDS - MIDDLE_OFFSET);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEED_MUL,
        S_SEED_ADD,
        S_MID,
        S_TW
    } t_state;

    t_state                     r_state;
    logic                       r_seeded;
    logic [AW-1:0]              r_pos;
    logic [AW-1:0]              r_k;
    logic [mtg_pkg::WORD_W-1:0] r_prev;
    logic [mtg_pkg::WORD_W-1:0] r_prod;
    logic [mtg_pkg::WORD_W-1:0] r_w_pos;
    logic [mtg_pkg::WORD_W-1:0] r_w_next;
    logic                       r_out_valid;
    logic [mtg_pkg::WORD_W-1:0] r_out_word;

    logic                       in_accept;
    logic                       out_free;
    logic [AW-1:0]              pos_next;
    logic [AW-1:0]              pos_mid;
    logic [mtg_pkg::WORD_W-1:0] n_prod;
    logic [mtg_pkg::WORD_W-1:0] n_seed_word;

    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [mtg_pkg::WORD_W-1:0] ram_wdata;
    logic [AW-1:0]              ram_raddr_a;
    logic [mtg_pkg::WORD_W-1:0] ram_rdata_a;
    logic [mtg_pkg::WORD_W-1:0] ram_rdata_b;

    mtg_pkg::t_twist_in         twist_in;
    logic [mtg_pkg::WORD_W-1:0] twist_word;
    logic [mtg_pkg::WORD_W-1:0] twist_tempered;

    assign in_accept = i_in.valid && i_in.ready;
    assign out_free  = !r_out_valid || o_out.ready;

    assign i_in.ready                = (r_state == S_IDLE);
    assign o_out.valid               = r_out_valid;
    assign o_out.payload.random_word = r_out_word;

    assign pos_next = (r_pos == LAST_ADDR) ? '0 : r_pos + AW'(1);
    assign pos_mid  = (r_pos < MID_SPLIT) ? r_pos + MID_OFF : r_pos - MID_SPLIT;

    assign n_prod      = mtg_pkg::SEED_MULT * (r_prev ^ (r_prev >> 30));
    assign n_seed_word = r_prod + mtg_pkg::WORD_W'(r_k);

    // Port A reads the current word, then holds the middle word until write-back.
    assign ram_raddr_a = (r_state == S_MID || r_state == S_TW) ? pos_mid : r_pos;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_pos;
        ram_wdata = twist_word;
        case (r_state)
            S_IDLE: begin
                if (in_accept && i_in.payload.op == mtg_pkg::OP_SEED) begin
                    ram_we    = 1'b1;
                    ram_waddr = '0;
                    ram_wdata = i_in.payload.seed_value;
                end
            end
            S_SEED_ADD: begin
                ram_we    = 1'b1;
                ram_waddr = r_k;
                ram_wdata = n_seed_word;
            end
            S_TW: begin
                ram_we = out_free && r_seeded;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    mtg_ram #(
        .WIDTH (mtg_pkg::WORD_W),
        .DEPTH (STATE_WORDS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (ram_raddr_a),
        .i_raddr_b (pos_next),
        .o_rdata_a (ram_rdata_a),
        .o_rdata_b (ram_rdata_b)
    );

    assign twist_in.w_pos  = r_w_pos;
    assign twist_in.w_next = r_w_next;
    assign twist_in.w_mid  = ram_rdata_a;

    mtg_twist u_twist (
        .i_words    (twist_in),
        .o_new_word (twist_word),
        .o_tempered (twist_tempered)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seeded    <= 1'b0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // drop a taken result unless a new word takes its place
            if (o_out.ready && !(r_state == S_TW && out_free)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        if (i_in.payload.op == mtg_pkg::OP_SEED) begin
                            r_prev  <= i_in.payload.seed_value;
                            r_k     <= AW'(1);
                            r_state <= S_SEED_MUL;
                        end else begin
                            r_state <= S_MID;
                        end
                    end
                end
                S_SEED_MUL: begin
                    r_prod  <= n_prod;
                    r_state <= S_SEED_ADD;
                end
                S_SEED_ADD: begin
                    r_prev <= n_seed_word;
                    if (r_k == LAST_ADDR) begin
                        r_seeded <= 1'b1;
                        r_pos    <= '0;
                        r_state  <= S_IDLE;
                    end else begin
                        r_k     <= r_k + AW'(1);
                        r_state <= S_SEED_MUL;
                    end
                end
                S_MID: begin
                    r_w_pos  <= ram_rdata_a;
                    r_w_next <= ram_rdata_b;
                    r_state  <= S_TW;
                end
                S_TW: begin
                    // hold until the output register can take the word
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_word  <= r_seeded ? twist_tempered : '0;
                        r_pos       <= pos_next;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> sv/mtg_checker.sv
// Port-level checks of the generator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "mersenne_twister_generator_defines.svh"

module mtg_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_in_valid,
    input wire logic                       i_in_ready,
    input wire mtg_pkg::t_op               i_in_op,
    input wire logic                       i_out_valid,
    input wire logic                       i_out_ready,
    input wire logic [mtg_pkg::WORD_W-1:0] i_out_word
);

    // a stalled result keeps its word
    `MTG_ASSERT_NXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_word))

    // every transaction leaves the block busy in the cycle after it
    `MTG_ASSERT_NXT(a_busy_after_in, i_in_valid && i_in_ready, !i_in_ready)

    // a seed never produces a result right behind it
    `MTG_ASSERT_NXT(a_seed_silent, i_in_valid && i_in_ready && i_in_op == mtg_pkg::OP_SEED,
        !$rose(i_out_valid))

    // a result appears only out of work in progress
    `MTG_ASSERT_IMP(a_out_from_busy, $rose(i_out_valid), $past(!i_in_ready))

    // no result right out of reset
    `MTG_ASSERT_IMP(a_reset_clean, $past(!i_rst_n), !i_out_valid)

endmodule

bind mersenne_twister_generator mtg_checker u_mtg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_op     (i_in.payload.op),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_word  (o_out.payload.random_word)
);

`default_nettype wire
